>>> hw/rtl/quoted_string_unescape_utf8_top_defines.svh
// Assertion macros used by the checker file of the quoted string unescaper.
// Each macro expects clk and rst_n to be visible in the scope where it is used.
`ifndef QUOTED_STRING_UNESCAPE_UTF8_TOP_DEFINES_SVH
`define QUOTED_STRING_UNESCAPE_UTF8_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define QSU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qsu assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define QSU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qsu assertion failed");

`endif

>>> hw/rtl/qsu_pkg.sv
// Package for the quoted string unescaper: item types, phase and kind codes,
// character constants and the hex digit and UTF-8 encoding helpers.
// No dependencies.
package qsu_pkg;

  typedef enum logic [3:0] {
    PH_FIN     = 4'd0,
    PH_BODY    = 4'd1,
    PH_ESC     = 4'd2,
    PH_QUAD1   = 4'd3,
    PH_SURR_BS = 4'd4,
    PH_SURR_U  = 4'd5,
    PH_QUAD2   = 4'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERR   = 2'd2
  } kind_t;

  localparam logic [7:0] QUOTE_RESET = 8'h22;
  localparam logic [7:0] CH_DQUOTE   = 8'h22;
  localparam logic [7:0] CH_APOS     = 8'h27;
  localparam logic [7:0] CH_SLASH    = 8'h2F;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_LB       = 8'h62;
  localparam logic [7:0] CH_LF       = 8'h66;
  localparam logic [7:0] CH_LN       = 8'h6E;
  localparam logic [7:0] CH_LR       = 8'h72;
  localparam logic [7:0] CH_LT       = 8'h74;
  localparam logic [7:0] CH_LU       = 8'h75;
  localparam logic [7:0] CTRL_LIMIT  = 8'h20;

  localparam logic [5:0] HI_SURR_TAG = 6'b110110;
  localparam logic [5:0] LO_SURR_TAG = 6'b110111;

  typedef struct packed {
    logic       start_req;
    logic       at_end;
    logic [7:0] in_byte;
  } item_in_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  out_byte;
    logic [15:0] err_off;
    logic        last;
  } item_out_t;

  // Fixed-width part of the decoder state.
  typedef struct packed {
    phase_t      phase;
    logic [15:0] acc;
    logic [1:0]  cnt;
    logic [9:0]  hs;
    logic        pend_v;
  } dec_st_t;

  // All results caused by one input item.
  typedef struct packed {
    kind_t           kind;
    logic [2:0]      n;
    logic [3:0][7:0] bytes;
    logic [15:0]     offset;
  } grp_t;

  typedef struct packed {
    logic [2:0]      n;
    logic [3:0][7:0] bytes;
  } utf8_t;

  // Bit 4 set when the byte is a hex digit, low nibble its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t r;
    r = '0;
    if (cp <= 21'h7F) begin
      r.n        = 3'd1;
      r.bytes[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      r.n        = 3'd2;
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      r.n        = 3'd3;
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      r.n        = 3'd4;
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/qsu_dec.sv
// Combinational decode of one registered input item against the current state.
// Produces the next state and the group of results for the item. Uses qsu_pkg.
module qsu_dec import qsu_pkg::*; #(
  parameter int OFFSET_BITS = 16
) (
  input  item_in_t               item,
  input  logic [7:0]             quote_char,
  input  dec_st_t                st,
  input  logic [OFFSET_BITS-1:0] pos,
  input  logic [OFFSET_BITS-1:0] qs,
  input  logic [OFFSET_BITS-1:0] pend_off,
  output dec_st_t                st_nxt,
  output logic [OFFSET_BITS-1:0] pos_nxt,
  output logic [OFFSET_BITS-1:0] qs_nxt,
  output logic [OFFSET_BITS-1:0] pend_off_nxt,
  output grp_t                   grp
);

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

  logic [OFFSET_BITS-1:0]  after;
  logic [OFFSET_BITS-1:0]  fail_off;
  logic [OFFSET_BITS+15:0] fail_wide;
  logic                    do_fail;
  logic                    do_clear;
  logic [4:0]              dig;
  logic [15:0]             acc_new;
  logic                    pend_v_new;
  logic [OFFSET_BITS-1:0]  pend_off_new;
  logic                    quad_done;
  logic [20:0]             pair_cp;
  utf8_t                   enc;
  logic [7:0]              b;

  assign b            = item.in_byte;
  assign after        = (pos == OFF_MAX) ? pos : pos + 1'b1;
  assign dig          = hex_digit(b);
  assign acc_new      = dig[4] ? {st.acc[11:0], dig[3:0]} : st.acc;
  assign pend_v_new   = st.pend_v | ~dig[4];
  assign pend_off_new = (st.pend_v || dig[4]) ? pend_off : after;
  assign quad_done    = (st.cnt == 2'd3);
  // Pair value: 0x10000 + (high << 10) + low bits of the low surrogate.
  assign pair_cp      = {({1'b0, st.hs} + 11'd64), acc_new[9:0]};
  assign fail_wide    = {16'b0, fail_off};

  always_comb begin
    st_nxt       = st;
    pos_nxt      = pos;
    qs_nxt       = qs;
    pend_off_nxt = pend_off;
    grp          = '0;
    grp.kind     = KIND_BYTE;
    do_fail      = 1'b0;
    do_clear     = 1'b0;
    fail_off     = '0;
    enc          = '0;

    if (item.start_req) begin
      if (item.at_end || b != quote_char) begin
        do_fail = 1'b1;
      end else begin
        st_nxt       = '0;
        st_nxt.phase = PH_BODY;
        qs_nxt       = '0;
        pend_off_nxt = '0;
        pos_nxt      = OFFSET_BITS'(1);
      end
    end else if (st.phase == PH_FIN) begin
      // Nothing is open: the item is dropped.
    end else if (item.at_end) begin
      do_fail  = 1'b1;
      fail_off = (st.phase == PH_BODY || st.phase == PH_ESC) ? pos : qs;
    end else begin
      pos_nxt = after;
      unique case (st.phase)
        PH_BODY: begin
          if (b == quote_char) begin
            grp.kind = KIND_CLOSE;
            grp.n    = 3'd1;
            do_clear = 1'b1;
          end else if (b < CTRL_LIMIT) begin
            do_fail  = 1'b1;
            fail_off = pos;
          end else if (b == CH_BSLASH) begin
            st_nxt.phase = PH_ESC;
          end else begin
            grp.n        = 3'd1;
            grp.bytes[0] = b;
          end
        end
        PH_ESC: begin
          st_nxt.phase = PH_BODY;
          grp.n        = 3'd1;
          unique case (b)
            CH_DQUOTE: grp.bytes[0] = CH_DQUOTE;
            CH_BSLASH: grp.bytes[0] = CH_BSLASH;
            CH_SLASH:  grp.bytes[0] = CH_SLASH;
            CH_LB:     grp.bytes[0] = 8'h08;
            CH_LF:     grp.bytes[0] = 8'h0C;
            CH_LN:     grp.bytes[0] = 8'h0A;
            CH_LR:     grp.bytes[0] = 8'h0D;
            CH_LT:     grp.bytes[0] = 8'h09;
            CH_APOS: begin
              if (quote_char == CH_APOS) begin
                grp.bytes[0] = CH_APOS;
              end else begin
                do_fail  = 1'b1;
                fail_off = pos;
              end
            end
            CH_LU: begin
              grp.n         = 3'd0;
              st_nxt.phase  = PH_QUAD1;
              st_nxt.acc    = '0;
              st_nxt.cnt    = '0;
              st_nxt.pend_v = 1'b0;
              qs_nxt        = after;
            end
            default: begin
              do_fail  = 1'b1;
              fail_off = pos;
            end
          endcase
        end
        PH_QUAD1, PH_QUAD2: begin
          st_nxt.acc    = acc_new;
          st_nxt.cnt    = st.cnt + 2'd1;
          st_nxt.pend_v = pend_v_new;
          pend_off_nxt  = pend_off_new;
          if (quad_done) begin
            st_nxt.cnt = 2'd0;
            if (pend_v_new) begin
              do_fail  = 1'b1;
              fail_off = pend_off_new;
            end else if (st.phase == PH_QUAD1) begin
              if (acc_new[15:10] == HI_SURR_TAG) begin
                st_nxt.hs    = acc_new[9:0];
                st_nxt.phase = PH_SURR_BS;
                qs_nxt       = after;
              end else if (acc_new[15:10] == LO_SURR_TAG) begin
                do_fail  = 1'b1;
                fail_off = after;
              end else begin
                enc          = utf8_encode({5'd0, acc_new});
                st_nxt.phase = PH_BODY;
              end
            end else if (acc_new[15:10] != LO_SURR_TAG) begin
              do_fail  = 1'b1;
              fail_off = after;
            end else begin
              enc          = utf8_encode(pair_cp);
              st_nxt.phase = PH_BODY;
            end
            grp.n     = enc.n;
            grp.bytes = enc.bytes;
          end
        end
        PH_SURR_BS: begin
          if (b == CH_BSLASH) begin
            st_nxt.phase = PH_SURR_U;
          end else begin
            do_fail  = 1'b1;
            fail_off = qs;
          end
        end
        PH_SURR_U: begin
          if (b == CH_LU) begin
            st_nxt.phase  = PH_QUAD2;
            st_nxt.acc    = '0;
            st_nxt.cnt    = '0;
            st_nxt.pend_v = 1'b0;
            qs_nxt        = after;
          end else begin
            do_fail  = 1'b1;
            fail_off = qs;
          end
        end
        default: do_clear = 1'b1;
      endcase
    end

    if (do_fail) begin
      grp.kind   = KIND_ERR;
      grp.n      = 3'd1;
      grp.bytes  = '0;
      grp.offset = fail_wide[15:0];
      do_clear   = 1'b1;
    end
    if (do_clear) begin
      st_nxt       = '0;
      st_nxt.phase = PH_FIN;
      pos_nxt      = '0;
      qs_nxt       = '0;
      pend_off_nxt = '0;
    end
  end

endmodule

>>> hw/rtl/qsu_out.sv
// Result register of the quoted string unescaper: holds one result group and
// hands its items out one per cycle while out_ready is high. Uses qsu_pkg.
module qsu_out import qsu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  grp_t      grp_in,
  input  logic      grp_load,
  output logic      grp_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output item_out_t out_data
);

  logic       grp_v_r, grp_v_nxt;
  grp_t       grp_r;
  logic [1:0] idx_r, idx_nxt;
  logic       is_last;

  assign is_last   = ({1'b0, idx_r} == grp_r.n - 3'd1);
  assign grp_ready = !grp_v_r || (out_ready && is_last);
  assign out_valid = grp_v_r;

  always_comb begin
    out_data          = '0;
    out_data.kind     = grp_r.kind;
    out_data.last     = is_last;
    out_data.out_byte = (grp_r.kind == KIND_BYTE) ? grp_r.bytes[idx_r] : 8'd0;
    out_data.err_off  = (grp_r.kind == KIND_ERR) ? grp_r.offset : 16'd0;
  end

  always_comb begin
    grp_v_nxt = grp_v_r;
    idx_nxt   = idx_r;
    if (grp_v_r && out_ready) begin
      if (is_last) begin
        grp_v_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
    if (grp_load) begin
      grp_v_nxt = 1'b1;
      idx_nxt   = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_v_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      grp_v_r <= grp_v_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_load) begin
      grp_r <= grp_in;
    end
  end

endmodule

>>> hw/rtl/quoted_string_unescape_utf8_top.sv
// Quoted string unescaper with UTF-8 expansion: top level.
// Holds the input register, decoder state and quote register; instantiates
// qsu_dec and qsu_out. Uses qsu_pkg.
//
// Usage: in_data carries one raw byte of a quoted string per item, with
// start_req on the opening quote and at_end to signal end of input. Each item
// yields zero to four result items on out_data: decoded bytes, a close marker,
// or an error with its byte offset. The last result of an item has last set.
// cfg_data sets the quote byte and is always ready; write it only while idle.
// An accepted item is held in the input register and decoded from there; its
// results are loaded into the result register, which drives out_data.
// Throughput: one item per cycle while each item yields at most one result and
// out_ready stays high; an item with several results holds the result register
// until all are taken, which slows multi-byte UTF-8 sequences.
// A stalled out_ready holds the result; the input register keeps taking items
// that cause no result, and in_ready falls once it holds an item with results
// while the result register is still busy.
// Reset clears all state, sets the quote byte to a double quote and leaves
// the block waiting for a start item; no memory needs clearing.
module quoted_string_unescape_utf8_top import qsu_pkg::*; #(
  parameter int OFFSET_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  item_in_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output item_out_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic                   in_v_r;
  item_in_t               in_item_r;
  logic [7:0]             quote_r;
  dec_st_t                st_r, st_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] qs_r, qs_nxt;
  logic [OFFSET_BITS-1:0] pend_off_r, pend_off_nxt;
  grp_t                   grp;
  logic                   grp_ready;
  logic                   consume;
  logic                   grp_load;

  assign cfg_ready = 1'b1;
  // Items without results retire even while the result register is busy.
  assign consume   = in_v_r && (grp.n == 3'd0 || grp_ready);
  assign grp_load  = consume && (grp.n != 3'd0);
  assign in_ready  = !in_v_r || consume;

  qsu_dec #(.OFFSET_BITS(OFFSET_BITS)) u_dec (
    .item         (in_item_r),
    .quote_char   (quote_r),
    .st           (st_r),
    .pos          (pos_r),
    .qs           (qs_r),
    .pend_off     (pend_off_r),
    .st_nxt       (st_nxt),
    .pos_nxt      (pos_nxt),
    .qs_nxt       (qs_nxt),
    .pend_off_nxt (pend_off_nxt),
    .grp          (grp)
  );

  qsu_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp_in    (grp),
    .grp_load  (grp_load),
    .grp_ready (grp_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The all-zero state is the finished phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r       <= 1'b0;
      quote_r      <= QUOTE_RESET;
      st_r         <= '0;
      pos_r        <= '0;
      qs_r         <= '0;
      pend_off_r   <= '0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (cfg_valid && cfg_ready) begin
        quote_r <= cfg_data;
      end
      if (consume) begin
        st_r       <= st_nxt;
        pos_r      <= pos_nxt;
        qs_r       <= qs_nxt;
        pend_off_r <= pend_off_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
  end

endmodule

>>> hw/rtl/qsu_chk.sv
// Port-level checker for the quoted string unescaper, bound to the top level.
// Uses qsu_pkg and the assertion macros of the defines header.
`include "quoted_string_unescape_utf8_top_defines.svh"

module qsu_chk import qsu_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input item_out_t out_data
);

  `QSU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // A close marker or an error always ends the results of its item.
  `QSU_ASSERT_NOW(a_end_last, out_valid && out_data.kind != KIND_BYTE, out_data.last)

  `QSU_ASSERT_NOW(a_byte_zero, out_valid && out_data.kind != KIND_BYTE, out_data.out_byte == 8'd0)

  `QSU_ASSERT_NOW(a_off_zero, out_valid && out_data.kind != KIND_ERR, out_data.err_off == 16'd0)

endmodule

bind quoted_string_unescape_utf8_top qsu_chk u_qsu_chk (.*);

>>> sim/tb_quoted_string_unescape_utf8_top.sv
// Self-checking testbench for quoted_string_unescape_utf8_top: drives raw bytes of
// quoted strings, decodes them in a predictor and compares every result item.
// Depends on qsu_pkg and the RTL of the block; no files or arguments.
module tb_quoted_string_unescape_utf8_top import qsu_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SHOWN         = 10;
  localparam int WATCHDOG_LIMIT    = 5000;
  localparam int SETTLE_CYCLES     = 8;
  localparam int ITEMS_PER_SETTING = 30;

  localparam logic [15:0] SURR_HI_MIN = 16'hD800;
  localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
  localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
  localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE   = 21'h10000;
  localparam logic [15:0] POS_MAX     = 16'hFFFF;

  localparam logic [7:0] ASCII_BS  = 8'h08;
  localparam logic [7:0] ASCII_TAB = 8'h09;
  localparam logic [7:0] ASCII_NL  = 8'h0A;
  localparam logic [7:0] ASCII_FF  = 8'h0C;
  localparam logic [7:0] ASCII_CR  = 8'h0D;

  typedef enum int {
    FLAW_NONE, FLAW_BAD_START, FLAW_CTRL, FLAW_BAD_ESC, FLAW_APOS, FLAW_BAD_HEX,
    FLAW_SHORT_QUAD, FLAW_LONE_LOW, FLAW_NO_BSLASH, FLAW_NO_U, FLAW_BAD_LOW,
    FLAW_END_BODY, FLAW_END_ESC, FLAW_END_SURR, FLAW_RESTART
  } flaw_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid = 1'b0;
  logic       in_ready;
  item_in_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  item_out_t  out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;

  quoted_string_unescape_utf8_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state.
  logic [7:0]  quote_reg;
  phase_t      ph;
  logic [15:0] pos;
  logic [15:0] acc;
  logic [2:0]  quad_cnt;
  logic [9:0]  hs;
  logic [15:0] qstart;
  logic        pend_v;
  logic [15:0] pend_off;
  item_out_t   step_results[$];
  item_out_t   expected_decode[$];

  // Stimulus and bookkeeping.
  item_in_t   raw_items[$];
  logic [7:0] cur_quote = QUOTE_RESET;
  int         gen_items = 0;
  int         settings_used = 0;
  logic       in_took = 1'b0;
  int         gap_left = 0;
  int         burst_left = 0;
  int         rx_left = 0;
  rx_mode_t   rx_mode = RX_OPEN;
  int         idle_cycles = 0;
  int         items_in = 0;
  int         results_seen = 0;
  int         closes_seen = 0;
  int         errors_seen = 0;
  int         failures = 0;

  function automatic void clear_dec();
    ph       = PH_FIN;
    pos      = '0;
    acc      = '0;
    quad_cnt = '0;
    hs       = '0;
    qstart   = '0;
    pend_v   = 1'b0;
    pend_off = '0;
  endfunction

  function automatic void emit(input kind_t k, input logic [7:0] b, input logic [15:0] off);
    item_out_t r;
    r.kind     = k;
    r.out_byte = b;
    r.err_off  = off;
    r.last     = 1'b0;
    step_results = {step_results, r};
  endfunction

  function automatic void abort_str(input logic [15:0] off);
    emit(KIND_ERR, 8'h00, off);
    clear_dec();
  endfunction

  function automatic void begin_quad(input logic [15:0] start);
    qstart   = start;
    acc      = '0;
    quad_cnt = '0;
    pend_v   = 1'b0;
    pend_off = '0;
  endfunction

  function automatic int nibble_of(input logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return int'(b) - 'h30;
    if (b >= 8'h61 && b <= 8'h66) return int'(b) - 'h61 + 10;
    if (b >= 8'h41 && b <= 8'h46) return int'(b) - 'h41 + 10;
    return -1;
  endfunction

  // Only the first bad digit of a quad is remembered; the rest are just counted.
  function automatic bit quad_take(input logic [7:0] b, input logic [15:0] after);
    int d;
    d = nibble_of(b);
    if (d < 0) begin
      if (!pend_v) begin
        pend_v   = 1'b1;
        pend_off = after;
      end
    end else begin
      acc = {acc[11:0], d[3:0]};
    end
    quad_cnt = quad_cnt + 3'd1;
    if (quad_cnt >= 3'd4) begin
      quad_cnt = 3'd0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void emit_utf8(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      emit(KIND_BYTE, cp[7:0], 16'd0);
    end else if (cp <= 21'h7FF) begin
      emit(KIND_BYTE, 8'hC0 | {3'b0, cp[10:6]}, 16'd0);
      emit(KIND_BYTE, 8'h80 | {2'b0, cp[5:0]}, 16'd0);
    end else if (cp <= 21'hFFFF) begin
      emit(KIND_BYTE, 8'hE0 | {4'b0, cp[15:12]}, 16'd0);
      emit(KIND_BYTE, 8'h80 | {2'b0, cp[11:6]}, 16'd0);
      emit(KIND_BYTE, 8'h80 | {2'b0, cp[5:0]}, 16'd0);
    end else begin
      emit(KIND_BYTE, 8'hF0 | {5'b0, cp[20:18]}, 16'd0);
      emit(KIND_BYTE, 8'h80 | {2'b0, cp[17:12]}, 16'd0);
      emit(KIND_BYTE, 8'h80 | {2'b0, cp[11:6]}, 16'd0);
      emit(KIND_BYTE, 8'h80 | {2'b0, cp[5:0]}, 16'd0);
    end
  endfunction

  // Works out the result items of one accepted input item.
  function automatic void decode_item(input item_in_t it);
    logic [15:0] here;
    logic [15:0] after;
    logic [7:0]  b;
    b = it.in_byte;
    if (it.start_req) begin
      clear_dec();
      if (it.at_end || b != quote_reg) begin
        abort_str(16'd0);
      end else begin
        ph  = PH_BODY;
        pos = 16'd1;
      end
    end else if (ph != PH_FIN) begin
      if (it.at_end) begin
        abort_str((ph == PH_BODY || ph == PH_ESC) ? pos : qstart);
      end else begin
        here  = pos;
        after = (pos == POS_MAX) ? pos : pos + 16'd1;
        pos   = after;
        case (ph)
          PH_BODY: begin
            if (b == quote_reg) begin
              emit(KIND_CLOSE, 8'h00, 16'd0);
              clear_dec();
            end else if (b < CTRL_LIMIT) begin
              abort_str(here);
            end else if (b == CH_BSLASH) begin
              ph = PH_ESC;
            end else begin
              emit(KIND_BYTE, b, 16'd0);
            end
          end
          PH_ESC: begin
            ph = PH_BODY;
            case (b)
              CH_DQUOTE: emit(KIND_BYTE, CH_DQUOTE, 16'd0);
              CH_APOS: begin
                if (quote_reg == CH_APOS) emit(KIND_BYTE, CH_APOS, 16'd0);
                else abort_str(here);
              end
              CH_BSLASH: emit(KIND_BYTE, CH_BSLASH, 16'd0);
              CH_SLASH:  emit(KIND_BYTE, CH_SLASH, 16'd0);
              CH_LB:     emit(KIND_BYTE, ASCII_BS, 16'd0);
              CH_LF:     emit(KIND_BYTE, ASCII_FF, 16'd0);
              CH_LN:     emit(KIND_BYTE, ASCII_NL, 16'd0);
              CH_LR:     emit(KIND_BYTE, ASCII_CR, 16'd0);
              CH_LT:     emit(KIND_BYTE, ASCII_TAB, 16'd0);
              CH_LU: begin
                begin_quad(after);
                ph = PH_QUAD1;
              end
              default:   abort_str(here);
            endcase
          end
          PH_QUAD1: begin
            if (quad_take(b, after)) begin
              if (pend_v) begin
                abort_str(pend_off);
              end else if (acc >= SURR_HI_MIN && acc <= SURR_HI_MAX) begin
                // The low ten bits of D800 are zero, so they are the surrogate payload.
                hs     = acc[9:0];
                qstart = after;
                ph     = PH_SURR_BS;
              end else if (acc >= SURR_LO_MIN && acc <= SURR_LO_MAX) begin
                abort_str(after);
              end else begin
                emit_utf8({5'd0, acc});
                ph = PH_BODY;
              end
            end
          end
          PH_SURR_BS: begin
            if (b == CH_BSLASH) ph = PH_SURR_U;
            else abort_str(qstart);
          end
          PH_SURR_U: begin
            if (b == CH_LU) begin
              begin_quad(after);
              ph = PH_QUAD2;
            end else begin
              abort_str(qstart);
            end
          end
          PH_QUAD2: begin
            if (quad_take(b, after)) begin
              if (pend_v) begin
                abort_str(pend_off);
              end else if (acc < SURR_LO_MIN || acc > SURR_LO_MAX) begin
                abort_str(after);
              end else begin
                emit_utf8(SUPP_BASE + {1'b0, hs, acc[9:0]});
                ph = PH_BODY;
              end
            end
          end
          default: clear_dec();
        endcase
      end
    end
    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
    while (step_results.size() > 0)
      expected_decode = {expected_decode, step_results.pop_front()};
  endfunction

  // Stimulus helpers.
  task automatic push_item(input logic s, input logic e, input logic [7:0] b);
    item_in_t it;
    it.start_req = s;
    it.at_end    = e;
    it.in_byte   = b;
    raw_items = {raw_items, it};
    gen_items++;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + {4'd0, n};
    return (($urandom_range(0, 1) != 0) ? 8'h41 : 8'h61) + {4'd0, n} - 8'd10;
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(32, 255)); while (b == cur_quote || b == CH_BSLASH);
    return b;
  endfunction

  task automatic push_quad(input logic [15:0] v);
    push_item(1'b0, 1'b0, hex_char(v[15:12]));
    push_item(1'b0, 1'b0, hex_char(v[11:8]));
    push_item(1'b0, 1'b0, hex_char(v[7:4]));
    push_item(1'b0, 1'b0, hex_char(v[3:0]));
  endtask

  task automatic push_uesc(input logic [15:0] v);
    push_item(1'b0, 1'b0, CH_BSLASH);
    push_item(1'b0, 1'b0, CH_LU);
    push_quad(v);
  endtask

  // One well-formed piece of string body.
  task automatic add_segment();
    logic [7:0]  e;
    logic [15:0] cp;
    int          k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        for (k = 0; k < $urandom_range(1, 3); k++) push_item(1'b0, 1'b0, plain_byte());
      end
      5, 6: begin
        case ($urandom_range(0, 8))
          0: e = CH_DQUOTE;
          1: e = (cur_quote == CH_APOS) ? CH_APOS : CH_DQUOTE;
          2: e = CH_BSLASH;
          3: e = CH_SLASH;
          4: e = CH_LB;
          5: e = CH_LF;
          6: e = CH_LN;
          7: e = CH_LR;
          default: e = CH_LT;
        endcase
        push_item(1'b0, 1'b0, CH_BSLASH);
        push_item(1'b0, 1'b0, e);
      end
      7, 8: begin
        case ($urandom_range(0, 4))
          0: cp = 16'($urandom_range(0, 16'h7F));
          1: cp = 16'($urandom_range(16'h80, 16'h7FF));
          2: cp = 16'($urandom_range(16'h800, 16'hD7FF));
          3: cp = 16'($urandom_range(16'hE000, 16'hFFFF));
          default: begin
            case ($urandom_range(0, 5))
              0: cp = 16'h0000;
              1: cp = 16'h007F;
              2: cp = 16'h0080;
              3: cp = 16'h07FF;
              4: cp = 16'h0800;
              default: cp = 16'hFFFF;
            endcase
          end
        endcase
        push_uesc(cp);
      end
      default: begin
        push_uesc(SURR_HI_MIN + 16'($urandom_range(0, 16'h3FF)));
        push_uesc(SURR_LO_MIN + 16'($urandom_range(0, 16'h3FF)));
      end
    endcase
  endtask

  // Waits until the block has nothing left to say, plus a margin for items
  // that cause no result.
  task automatic drain();
    do @(posedge clk); while (raw_items.size() != 0 || in_valid || expected_decode.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Driver: new item at the falling edge once the previous one was taken.
  always @(negedge clk) begin : driver
    logic     v;
    logic     r;
    item_in_t nxt;
    v   = in_valid;
    nxt = in_data;
    r   = 1'b0;
    if (!rst_n) begin
      v = 1'b0;
    end else begin
      if (!in_valid || in_took) begin
        v = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (raw_items.size() > 0) begin
          nxt = raw_items.pop_front();
          v   = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            case ($urandom_range(0, 7))
              0, 1, 2: gap_left = 0;
              3:       gap_left = $urandom_range(8, 25);
              default: gap_left = $urandom_range(1, 3);
            endcase
          end
        end
      end
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(RX_OPEN, RX_PERIODIC));
        rx_left = $urandom_range(16, 64);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_OPEN:   r = 1'b1;
        RX_COIN:   r = ($urandom_range(0, 1) != 0);
        RX_SPARSE: r = ($urandom_range(0, 4) == 0);
        default:   r = (rx_left % 7 == 0);
      endcase
    end
    in_valid  <= v;
    in_data   <= nxt;
    out_ready <= r;
  end

  // Monitor: predicts on every accepted item and checks every accepted result.
  always @(posedge clk) begin : monitor
    item_out_t want;
    if (!rst_n) begin
      quote_reg = QUOTE_RESET;
      clear_dec();
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (cfg_valid && cfg_ready) quote_reg = cfg_data;
      if (in_valid && in_ready) begin
        decode_item(in_data);
        items_in++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_data.kind == KIND_CLOSE) closes_seen++;
        if (out_data.kind == KIND_ERR) errors_seen++;
        if (expected_decode.size() == 0) begin
          failures++;
          if (failures <= MAX_SHOWN)
            $display("unexpected result %0d: kind %0d byte %02h offset %0d last %0d",
                     results_seen, out_data.kind, out_data.out_byte,
                     out_data.err_off, out_data.last);
        end else begin
          want = expected_decode.pop_front();
          if (out_data.kind !== want.kind || out_data.out_byte !== want.out_byte ||
              out_data.err_off !== want.err_off || out_data.last !== want.last) begin
            failures++;
            if (failures <= MAX_SHOWN) begin
              $display("mismatch on result %0d: expected kind %0d byte %02h offset %0d last %0d",
                       results_seen, want.kind, want.out_byte, want.err_off, want.last);
              $display("  got kind %0d byte %02h offset %0d last %0d",
                       out_data.kind, out_data.out_byte, out_data.err_off, out_data.last);
            end
          end
        end
      end
    end
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)))
      idle_cycles = 0;
    else
      idle_cycles++;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
             idle_cycles, expected_decode.size());
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    flaw_t       flaw;
    logic [7:0]  q;
    logic [7:0]  x;
    logic [15:0] hi;
    item_in_t    stray;
    int          s;
    int          k;
    int          nseg;
    int          at;
    int          bad;
    int          cut;
    int          target;

    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: byte extremes and an escape, a surrogate pair, the start errors,
    // a control byte and an item that arrives while no string is open.
    push_item(1'b1, 1'b0, CH_DQUOTE);
    push_item(1'b0, 1'b0, 8'hFF);
    push_item(1'b0, 1'b0, 8'h20);
    push_item(1'b0, 1'b0, CH_BSLASH);
    push_item(1'b0, 1'b0, CH_SLASH);
    push_item(1'b0, 1'b0, CH_DQUOTE);
    push_item(1'b1, 1'b0, CH_DQUOTE);
    push_uesc(16'hD83D);
    push_uesc(16'hDE00);
    push_item(1'b0, 1'b0, CH_DQUOTE);
    push_item(1'b1, 1'b1, 8'h00);
    push_item(1'b1, 1'b0, 8'h00);
    push_item(1'b1, 1'b0, CH_DQUOTE);
    push_item(1'b0, 1'b0, 8'h1F);
    push_item(1'b0, 1'b1, 8'hA5);

    for (s = 0; s < 6; s++) begin
      case (s)
        0: q = CH_APOS;
        1: q = 8'h00;
        2: q = 8'hFF;
        3: q = 8'($urandom_range(0, 255));
        4: q = CH_BSLASH;
        default: q = QUOTE_RESET;
      endcase
      // The sender holds here until every expected result has come back.
      drain();
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_data  <= q;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      cur_quote = q;
      settings_used++;
      @(negedge clk);
      cfg_valid <= 1'b0;

      target = gen_items + ITEMS_PER_SETTING;
      while (gen_items < target) begin
        flaw = FLAW_NONE;
        if ($urandom_range(0, 2) == 0) flaw = flaw_t'($urandom_range(FLAW_BAD_START, FLAW_RESTART));
        if (flaw == FLAW_BAD_START) begin
          x = 8'($urandom_range(1, 255));
          if ($urandom_range(0, 1) != 0) push_item(1'b1, 1'b1, 8'($urandom_range(0, 255)));
          else push_item(1'b1, 1'b0, cur_quote ^ x);
        end else begin
          push_item(1'b1, 1'b0, cur_quote);
          nseg = $urandom_range(0, 6);
          at   = $urandom_range(0, nseg);
          for (k = 0; k < at; k++) add_segment();
          hi = SURR_HI_MIN + 16'($urandom_range(0, 16'h3FF));
          case (flaw)
            FLAW_NONE: begin
              for (k = at; k < nseg; k++) add_segment();
              push_item(1'b0, 1'b0, cur_quote);
            end
            FLAW_CTRL: push_item(1'b0, 1'b0, 8'($urandom_range(0, 31)));
            FLAW_BAD_ESC: begin
              push_item(1'b0, 1'b0, CH_BSLASH);
              push_item(1'b0, 1'b0, 8'($urandom_range(0, 255)));
            end
            FLAW_APOS: begin
              push_item(1'b0, 1'b0, CH_BSLASH);
              push_item(1'b0, 1'b0, CH_APOS);
            end
            FLAW_BAD_HEX: begin
              push_item(1'b0, 1'b0, CH_BSLASH);
              push_item(1'b0, 1'b0, CH_LU);
              bad = $urandom_range(0, 3);
              cut = 4;
              if (bad < 3 && $urandom_range(0, 2) == 0) cut = $urandom_range(bad + 1, 3);
              for (k = 0; k < cut; k++) begin
                if (k == bad || $urandom_range(0, 3) == 0) begin
                  do x = 8'($urandom_range(0, 255)); while (nibble_of(x) >= 0);
                end else begin
                  x = hex_char(4'($urandom_range(0, 15)));
                end
                push_item(1'b0, 1'b0, x);
              end
              // A quad cut short by the end of input reports the quad's start.
              if (cut < 4) push_item(1'b0, 1'b1, 8'($urandom_range(0, 255)));
            end
            FLAW_SHORT_QUAD: begin
              push_item(1'b0, 1'b0, CH_BSLASH);
              push_item(1'b0, 1'b0, CH_LU);
              for (k = 0; k < $urandom_range(0, 3); k++)
                push_item(1'b0, 1'b0, hex_char(4'($urandom_range(0, 15))));
              push_item(1'b0, 1'b1, 8'($urandom_range(0, 255)));
            end
            FLAW_LONE_LOW: push_uesc(SURR_LO_MIN + 16'($urandom_range(0, 16'h3FF)));
            FLAW_NO_BSLASH: begin
              push_uesc(hi);
              push_item(1'b0, 1'b0, 8'($urandom_range(0, 255)));
            end
            FLAW_NO_U: begin
              push_uesc(hi);
              push_item(1'b0, 1'b0, CH_BSLASH);
              push_item(1'b0, 1'b0, 8'($urandom_range(0, 255)));
            end
            FLAW_BAD_LOW: begin
              push_uesc(hi);
              push_uesc(16'($urandom_range(0, 16'hFFFF)));
            end
            FLAW_END_BODY: push_item(1'b0, 1'b1, 8'($urandom_range(0, 255)));
            FLAW_END_ESC: begin
              push_item(1'b0, 1'b0, CH_BSLASH);
              push_item(1'b0, 1'b1, 8'($urandom_range(0, 255)));
            end
            FLAW_END_SURR: begin
              push_uesc(hi);
              cut = $urandom_range(0, 5);
              if (cut > 0) push_item(1'b0, 1'b0, CH_BSLASH);
              if (cut > 1) push_item(1'b0, 1'b0, CH_LU);
              for (k = 2; k < cut; k++)
                push_item(1'b0, 1'b0, hex_char(4'($urandom_range(0, 15))));
              push_item(1'b0, 1'b1, 8'($urandom_range(0, 255)));
            end
            default: begin
              // Abandoned string: the next start item silently replaces it.
              if ($urandom_range(0, 1) != 0) push_item(1'b0, 1'b0, CH_BSLASH);
            end
          endcase
        end
        // Stray items after a finished string are dropped by the block.
        if (flaw != FLAW_RESTART && $urandom_range(0, 4) == 0) begin
          stray.start_req = 1'b0;
          stray.at_end    = ($urandom_range(0, 1) != 0);
          stray.in_byte   = 8'($urandom_range(0, 255));
          raw_items = {raw_items, stray};
        end
      end
    end

    drain();
    $display("run covered %0d items under %0d quote settings after the reset default",
             items_in, settings_used);
    $display("%0d results checked: %0d closed strings, %0d errors, %0d failures",
             results_seen, closes_seen, errors_seen, failures);
    if (failures == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
